// ----- hw/rtl/lpsd_pkg.sv -----
// lpsd_pkg: shared constants and types for the length-prefixed string deframer
// no dependencies; used by length_prefixed_string_deframer

package lpsd_pkg;

    // stream byte and length prefix geometry
    localparam int BYTE_W        = 8;
    localparam int GROUP_W       = 7;
    localparam int MORE_BIT      = 7;
    localparam int ACCUM_W       = 56;
    localparam int PREFIX_CNT_W  = 4;

    // default limit on prefix bytes per length
    localparam int DEF_MAX_PREFIX_BYTES = 8;

    // one result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              last_of_string;
        logic              empty_string;
        logic              length_error;
    } result_t;

endpackage

// ----- hw/rtl/length_prefixed_string_deframer.sv -----
// length_prefixed_string_deframer: splits a byte stream into strings with a vlq length prefix
// depends on lpsd_pkg (widths, defaults, result struct)
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+-----------
//   input   | s_valid s_ready s_in_byte                     | stream in
//   result  | m_valid m_ready m_char_byte m_last_of_string  | results out
//           | m_empty_string m_length_error                 |
//
// one byte per cycle while m_ready keeps the result register draining; a byte goes
// through the input register, then decode, into the result register, from which
// any result it yields is offered. the 56-bit remaining-count decrement and zero compare set
// the critical path. aresetn (synchronous, active low) returns the deframer to the
// length phase with an empty prefix. a stalled result register holds the decode
// stage, which fills the input register and then drops s_ready.

module length_prefixed_string_deframer #(
    parameter int MAX_PREFIX_BYTES = lpsd_pkg::DEF_MAX_PREFIX_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lpsd_pkg::BYTE_W-1:0] s_in_byte,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lpsd_pkg::BYTE_W-1:0] m_char_byte,
    output logic                        m_last_of_string,
    output logic                        m_empty_string,
    output logic                        m_length_error
);

    localparam int ACCUM_W = lpsd_pkg::ACCUM_W;
    localparam int CNT_W   = lpsd_pkg::PREFIX_CNT_W;
    localparam int GROUP_W = lpsd_pkg::GROUP_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PREFIX_BYTES);

    // input register
    logic                        in_valid_reg, in_valid_next;
    logic [lpsd_pkg::BYTE_W-1:0] in_byte_reg,  in_byte_next;

    // deframer state
    logic                        in_body_reg,  in_body_next;
    logic [ACCUM_W-1:0]          accum_reg,    accum_next;
    logic [CNT_W-1:0]            cnt_reg,      cnt_next;
    logic [ACCUM_W-1:0]          remain_reg,   remain_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    lpsd_pkg::result_t           result_reg,    result_next;

    // decode stage
    logic                        advance;
    logic                        emit;
    lpsd_pkg::result_t           res;
    logic [ACCUM_W-1:0]          remain_dec;
    logic [ACCUM_W-1:0]          accum_shift;

    // decode moves when it holds a byte and the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign remain_dec  = remain_reg - ACCUM_W'(1);
    assign accum_shift = {accum_reg[ACCUM_W-GROUP_W-1:0], in_byte_reg[GROUP_W-1:0]};

    always_comb begin
        in_body_next = in_body_reg;
        accum_next   = accum_reg;
        cnt_next     = cnt_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        res          = '0;

        if (advance) begin
            if (in_body_reg) begin
                // character phase: pass the byte on, flag the final one
                remain_next   = remain_dec;
                emit          = 1'b1;
                res.char_byte = in_byte_reg;
                if (remain_dec == '0) begin
                    in_body_next       = 1'b0;
                    res.last_of_string = 1'b1;
                end
            end else if (cnt_reg >= MAX_CNT) begin
                // prefix too long: drop this byte, report, restart the prefix
                accum_next       = '0;
                cnt_next         = '0;
                emit             = 1'b1;
                res.length_error = 1'b1;
            end else begin
                cnt_next   = cnt_reg + CNT_W'(1);
                accum_next = accum_shift;
                if (!in_byte_reg[lpsd_pkg::MORE_BIT]) begin
                    // prefix complete
                    accum_next = '0;
                    cnt_next   = '0;
                    if (accum_shift == '0) begin
                        emit             = 1'b1;
                        res.empty_string = 1'b1;
                    end else begin
                        remain_next  = accum_shift;
                        in_body_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_in_byte;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (advance) begin
            // a byte with no result still empties the result register
            out_valid_next = emit;
            result_next    = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_body_reg   <= 1'b0;
            accum_reg     <= '0;
            cnt_reg       <= '0;
            remain_reg    <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            in_body_reg   <= in_body_next;
            accum_reg     <= accum_next;
            cnt_reg       <= cnt_next;
            remain_reg    <= remain_next;
        end
        in_byte_reg <= in_byte_next;
        result_reg  <= result_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_char_byte      = result_reg.char_byte;
    assign m_last_of_string = result_reg.last_of_string;
    assign m_empty_string   = result_reg.empty_string;
    assign m_length_error   = result_reg.length_error;

    // a result carries at most one kind of marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_last_of_string, m_empty_string, m_length_error}))
        else $error("result carries more than one marker");

    // empty and error results carry no character
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_empty_string || m_length_error)) |-> (m_char_byte == '0))
        else $error("empty or error result with nonzero character");

    // in the character phase the prefix is cleared and characters remain
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_body_reg |-> (remain_reg != '0 && cnt_reg == '0 && accum_reg == '0))
        else $error("character phase with inconsistent length state");

    // a completed string goes back to the length phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit && res.last_of_string) |=> !in_body_reg)
        else $error("still in character phase after last character");

endmodule
